>>> hw/rtl/lrubp_pkg.sv
// ----------------------------------------------------------------------------
// lrubp_pkg
// shared types and codes for the lru buffer pool directory
// ----------------------------------------------------------------------------
package lrubp_pkg;

  localparam int TAG_W  = 16;
  localparam int PAGE_W = 32;
  localparam int PIN_W  = 15;
  localparam int FIDX_W = 4;

  localparam logic [PIN_W-1:0] PIN_MAX = {PIN_W{1'b1}};

  typedef enum logic [1:0] {
    KIND_GET    = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_UNPIN  = 2'd2,
    KIND_DEMOTE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_HIT     = 2'd0,
    ST_LOADED  = 2'd1,
    ST_ALLPIN  = 2'd2,
    ST_ABSENT  = 2'd3
  } status_t;

  // broadcast command from the sequencer to every frame cell
  typedef struct packed {
    logic              load;    // write new tag, clean, pins 1
    logic              pin;     // saturating increment
    logic              unpin;   // decrement to no lower than 0
    logic              dirty;   // mark dirty
    logic [TAG_W-1:0]  tbl;
    logic [PAGE_W-1:0] pg;
  } cell_cmd_t;

  // recency shift command to the order cells
  typedef struct packed {
    logic promote;  // move the chosen frame to the head
    logic demote;   // move the chosen frame to the tail
  } ord_cmd_t;

endpackage

>>> hw/rtl/lrubp_frame_cell.sv
// ----------------------------------------------------------------------------
// lrubp_frame_cell
// one frame of the directory: tag, valid, dirty and pin count
// ----------------------------------------------------------------------------
module lrubp_frame_cell
  import lrubp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              sel,
  input  cell_cmd_t         cmd,
  input  logic [TAG_W-1:0]  look_tbl,
  input  logic [PAGE_W-1:0] look_pg,
  output logic              hit,
  output logic              free,
  output logic              valid,
  output logic              dirty,
  output logic [TAG_W-1:0]  tbl,
  output logic [PAGE_W-1:0] pg,
  output logic [PIN_W-1:0]  pins
);

  // tag compare against the request
  assign hit  = valid && (tbl == look_tbl) && (pg == look_pg);
  assign free = (pins == '0);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      dirty <= 1'b0;
      pins  <= '0;
      tbl   <= '0;
      pg    <= '0;
    end else if (sel) begin
      if (cmd.load) begin
        valid <= 1'b1;
        dirty <= 1'b0;
        pins  <= {{(PIN_W-1){1'b0}}, 1'b1};
        tbl   <= cmd.tbl;
        pg    <= cmd.pg;
      end else begin
        if (cmd.dirty) dirty <= 1'b1;
        if (cmd.pin && pins != PIN_MAX) pins <= pins + 1'b1;
        if (cmd.unpin && pins != '0) pins <= pins - 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/lrubp_order_cell.sv
// ----------------------------------------------------------------------------
// lrubp_order_cell
// one position of the recency order; shifts from a neighbor on promote/demote
// ----------------------------------------------------------------------------
module lrubp_order_cell #(
  parameter int FW = 4,
  parameter int POS = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [1:0]    cmd,        // {demote, promote}
  input  logic [FW-1:0] target,
  input  logic          at_or_above,  // target sits at this position or nearer head
  input  logic          at_or_below,  // target sits at this position or nearer tail
  input  logic          is_head,
  input  logic          is_tail,
  input  logic [FW-1:0] from_prev,
  input  logic [FW-1:0] from_next,
  output logic [FW-1:0] frame
);

  // shift toward tail on promote, toward head on demote
  always_ff @(posedge clk) begin
    if (rst) begin
      frame <= FW'(POS);
    end else if (cmd[0] && at_or_below) begin
      frame <= is_head ? target : from_prev;
    end else if (cmd[1] && at_or_above) begin
      frame <= is_tail ? target : from_next;
    end
  end

endmodule

>>> hw/rtl/lru_buffer_pool_with_pinning_unit.sv
// ----------------------------------------------------------------------------
// lru_buffer_pool_with_pinning_unit
// lru tag directory of a page buffer with pin counts
// ----------------------------------------------------------------------------
// channel  dir  tuser   tdata
// s_axis   in   kind    table_tag, page_number
// m_axis   out  status  frame_index, writeback_needed/table/page, pins_after
//
// an accepted beat goes through lookup, victim pick, cell update and order
// shift while busy; the answer is loaded into the output register at the next edge
// a new beat is taken only in the cycle after the previous answer is taken,
// so the unit holds only one beat at a time
// reset clears all frames and sets frame i at order position i
// ----------------------------------------------------------------------------
module lru_buffer_pool_with_pinning_unit
  import lrubp_pkg::*;
#(
  parameter int NUM_FRAMES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [1:0]  s_axis_tuser,   // kind
  input  logic [47:0] s_axis_tdata,   // table_tag, page_number
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [1:0]  m_axis_tuser,   // status
  output logic [71:0] m_axis_tdata    // frame_index, writeback_needed,
                                      // writeback_table, writeback_page, pins_after
);

  localparam int FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;

  // request register
  logic              busy;
  kind_t             r_kind;
  logic [TAG_W-1:0]  r_tbl;
  logic [PAGE_W-1:0] r_pg;

  // cell views
  logic [NUM_FRAMES-1:0] hit, free, fvalid, fdirty, sel;
  logic [TAG_W-1:0]  ftbl [NUM_FRAMES];
  logic [PAGE_W-1:0] fpg  [NUM_FRAMES];
  logic [PIN_W-1:0]  fpin [NUM_FRAMES];
  logic [FW-1:0]     ord  [NUM_FRAMES];

  cell_cmd_t cmd;
  ord_cmd_t  ocmd;

  assign s_axis_tready = !busy && !m_axis_tvalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        busy   <= 1'b1;
        r_kind <= kind_t'(s_axis_tuser);
        r_tbl  <= s_axis_tdata[15:0];
        r_pg   <= s_axis_tdata[47:16];
      end else if (busy) begin
        busy <= 1'b0;
      end
    end
  end

  // frame cells
  for (genvar i = 0; i < NUM_FRAMES; i++) begin : g_frame
    lrubp_frame_cell u_cell (
      .clk(clk), .rst(rst), .sel(sel[i]), .cmd(cmd),
      .look_tbl(r_tbl), .look_pg(r_pg),
      .hit(hit[i]), .free(free[i]), .valid(fvalid[i]), .dirty(fdirty[i]),
      .tbl(ftbl[i]), .pg(fpg[i]), .pins(fpin[i])
    );
  end

  // hit frame and least recent unpinned frame
  logic          any_hit, any_free;
  logic [FW-1:0] hit_f, vic_f, tgt;
  always_comb begin
    any_hit = 1'b0;
    hit_f   = '0;
    for (int i = 0; i < NUM_FRAMES; i++) begin
      if (hit[i]) begin
        any_hit = 1'b1;
        hit_f   = FW'(i);
      end
    end
    any_free = 1'b0;
    vic_f    = '0;
    for (int p = 0; p < NUM_FRAMES; p++) begin
      if (free[ord[p]]) begin
        any_free = 1'b1;
        vic_f    = ord[p];
      end
    end
  end

  // decide the action
  logic      act, is_load;
  status_t   st;
  always_comb begin
    is_load = 1'b0;
    act     = 1'b0;
    tgt     = hit_f;
    st      = ST_HIT;
    case (r_kind)
      KIND_GET: begin
        if (any_hit) begin
          act = 1'b1;
        end else if (any_free) begin
          act = 1'b1; is_load = 1'b1; tgt = vic_f; st = ST_LOADED;
        end else begin
          st = ST_ALLPIN;
        end
      end
      default: begin
        if (any_hit) act = 1'b1;
        else st = ST_ABSENT;
      end
    endcase
    act = act && busy;
    cmd.load  = is_load;
    cmd.pin   = (r_kind == KIND_GET);
    cmd.unpin = (r_kind == KIND_UNPIN);
    cmd.dirty = (r_kind == KIND_WRITE);
    cmd.tbl   = r_tbl;
    cmd.pg    = r_pg;
    ocmd.promote = act && (r_kind == KIND_GET || r_kind == KIND_WRITE);
    ocmd.demote  = act && (r_kind == KIND_DEMOTE);
    for (int i = 0; i < NUM_FRAMES; i++) sel[i] = act && (tgt == FW'(i));
  end

  // order cells, a chain that shifts one step toward head or tail
  logic [NUM_FRAMES-1:0] match_pos, above, below;
  always_comb begin
    for (int p = 0; p < NUM_FRAMES; p++) match_pos[p] = (ord[p] == tgt);
    below[0] = match_pos[0];
    for (int p = 1; p < NUM_FRAMES; p++) below[p] = below[p-1] | match_pos[p];
    above[NUM_FRAMES-1] = match_pos[NUM_FRAMES-1];
    for (int p = NUM_FRAMES-2; p >= 0; p--) above[p] = above[p+1] | match_pos[p];
  end

  for (genvar p = 0; p < NUM_FRAMES; p++) begin : g_ord
    lrubp_order_cell #(.FW(FW), .POS(p)) u_ord (
      .clk(clk), .rst(rst), .cmd({ocmd.demote, ocmd.promote}), .target(tgt),
      .at_or_above(below[p]), .at_or_below(above[p]),
      .is_head(p == 0), .is_tail(p == NUM_FRAMES-1),
      .from_prev(ord[(p == 0) ? 0 : p-1]),
      .from_next(ord[(p == NUM_FRAMES-1) ? p : p+1]),
      .frame(ord[p])
    );
  end

  // result pins after the step
  logic [PIN_W-1:0] cur, pafter;
  always_comb begin
    cur = fpin[tgt];
    pafter = cur;
    if (is_load) pafter = {{(PIN_W-1){1'b0}}, 1'b1};
    else if (r_kind == KIND_GET && cur != PIN_MAX) pafter = cur + 1'b1;
    else if (r_kind == KIND_UNPIN && cur != '0) pafter = cur - 1'b1;
  end

  // answer fields, zero where the step touched no frame
  logic              wb;
  logic [FIDX_W-1:0] res_fidx;
  logic [TAG_W-1:0]  res_wbt;
  logic [PAGE_W-1:0] res_wbp;
  logic [PIN_W-1:0]  res_pins;
  always_comb begin
    wb       = is_load && fvalid[tgt] && fdirty[tgt];
    res_fidx = act ? FIDX_W'(tgt) : '0;
    res_wbt  = wb ? ftbl[tgt] : '0;
    res_wbp  = wb ? fpg[tgt] : '0;
    res_pins = act ? pafter : '0;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      if (busy) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tuser  <= st;
        m_axis_tdata  <= {4'b0, res_pins, res_wbp, res_wbt, wb, res_fidx};
      end
    end
  end

  // checks
  a_one_hit: assert property (@(posedge clk) disable iff (rst) $onehot0(hit))
    else $error("duplicate tag in directory");
  a_sel: assert property (@(posedge clk) disable iff (rst) $onehot0(sel))
    else $error("more than one frame selected");
  a_rdy: assert property (@(posedge clk) disable iff (rst) busy |=> m_axis_tvalid)
    else $error("answer missing after request");

endmodule
